### hw/rtl/gsp_pkg.sv
// ---------------------------------------------------------------------------
// gsp_pkg: shared types and constants for gripper stall protection
// Word layouts, register file layout, action codes and reset values.
// ---------------------------------------------------------------------------
package gsp_pkg;

    localparam int POS_W     = 14;
    localparam int TIME_W    = 32;
    localparam int TARGET_W  = 13;
    localparam int STALL_W   = 16;
    localparam int BACKOFF_W = 12;
    localparam int TOL_W     = 8;
    localparam int CLOSED_W  = 10;
    localparam int RELEASE_W = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [1:0] {
        ACT_GRAB    = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_SAMPLE  = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STALL_TIME = 3'd0,
        REG_BACK_OFF   = 3'd1,
        REG_MOVE_TOL   = 3'd2,
        REG_CLOSED_LIM = 3'd3,
        REG_RELEASE    = 3'd4
    } t_reg_idx;

    localparam logic [STALL_W-1:0]   STALL_TIME_RST = 16'd500;
    localparam logic [BACKOFF_W-1:0] BACK_OFF_RST   = 12'd200;
    localparam logic [TOL_W-1:0]     MOVE_TOL_RST   = 8'd5;
    localparam logic [CLOSED_W-1:0]  CLOSED_LIM_RST = 10'd50;
    localparam logic [RELEASE_W-1:0] RELEASE_RST    = 13'd1600;

    typedef struct packed {
        logic [STALL_W-1:0]   stall_time_ms;
        logic [BACKOFF_W-1:0] back_off_mrad;
        logic [TOL_W-1:0]     move_tolerance_mrad;
        logic [CLOSED_W-1:0]  closed_limit_mrad;
        logic [RELEASE_W-1:0] release_angle_mrad;
    } t_cfg;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [POS_W-1:0] position_mrad;
        logic [TIME_W-1:0]       time_ms;
    } t_in_word;

    typedef struct packed {
        logic [TARGET_W-1:0] target_mrad;
        logic                speed_level;
        logic                cause;
    } t_out_word;

endpackage

### hw/rtl/gsp_in_if.sv
// ---------------------------------------------------------------------------
// gsp_in_if: input channel
// Valid/ready channel carrying one command or position sample word.
// ---------------------------------------------------------------------------
interface gsp_in_if
    import gsp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              action;
    logic signed [POS_W-1:0] position_mrad;
    logic [TIME_W-1:0]       time_ms;

    modport source (output valid, action, position_mrad, time_ms, input ready);
    modport sink   (input valid, action, position_mrad, time_ms, output ready);
endinterface

### hw/rtl/gsp_out_if.sv
// ---------------------------------------------------------------------------
// gsp_out_if: output channel
// Valid/ready channel carrying one servo command word.
// ---------------------------------------------------------------------------
interface gsp_out_if
    import gsp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [TARGET_W-1:0] target_mrad;
    logic                speed_level;
    logic                cause;

    modport source (output valid, target_mrad, speed_level, cause, input ready);
    modport sink   (input valid, target_mrad, speed_level, cause, output ready);
endinterface

### hw/rtl/gsp_cfg_regs.sv
// ---------------------------------------------------------------------------
// gsp_cfg_regs: configuration register file
// Write-only registers, loaded by index; unknown indices are dropped.
// ---------------------------------------------------------------------------
module gsp_cfg_regs
    import gsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [CFG_DAT_W-1:0] i_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stall_time_ms       <= STALL_TIME_RST;
            r_cfg.back_off_mrad       <= BACK_OFF_RST;
            r_cfg.move_tolerance_mrad <= MOVE_TOL_RST;
            r_cfg.closed_limit_mrad   <= CLOSED_LIM_RST;
            r_cfg.release_angle_mrad  <= RELEASE_RST;
        end else if (i_wr_en) begin
            unique case (i_index)
                REG_STALL_TIME: r_cfg.stall_time_ms       <= i_wdata[STALL_W-1:0];
                REG_BACK_OFF:   r_cfg.back_off_mrad       <= i_wdata[BACKOFF_W-1:0];
                REG_MOVE_TOL:   r_cfg.move_tolerance_mrad <= i_wdata[TOL_W-1:0];
                REG_CLOSED_LIM: r_cfg.closed_limit_mrad   <= i_wdata[CLOSED_W-1:0];
                REG_RELEASE:    r_cfg.release_angle_mrad  <= i_wdata[RELEASE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/gsp_core.sv
// ---------------------------------------------------------------------------
// gsp_core: input register, stall tracking state and decision logic
// Holds one word; when the output side moves it updates the state and
// offers at most one command word.
// ---------------------------------------------------------------------------
module gsp_core
    import gsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_load,
    input  t_in_word  i_word,
    input  logic      i_advance,
    output logic      o_busy,
    output logic      o_res_valid,
    output t_out_word o_res
);

    logic                    r_in_valid;
    t_in_word                r_in;

    logic                    r_grab_active;
    logic signed [POS_W-1:0] r_prev_pos;
    logic                    r_prev_valid;
    logic [TIME_W-1:0]       r_stall_start;
    logic                    r_prot_fired;

    logic                    n_grab_active;
    logic signed [POS_W-1:0] n_prev_pos;
    logic                    n_prev_valid;
    logic [TIME_W-1:0]       n_stall_start;
    logic                    n_prot_fired;

    logic signed [POS_W:0]   pos_x;
    logic signed [POS_W:0]   diff;
    logic [POS_W:0]          diff_abs;
    logic signed [POS_W:0]   backed;
    logic [TIME_W-1:0]       elapsed;
    logic                    not_closed;
    logic                    still;
    logic                    fire;
    logic                    res_valid;
    t_out_word               res;

    assign pos_x      = {r_in.position_mrad[POS_W-1], r_in.position_mrad};
    assign not_closed = pos_x > $signed({{(POS_W+1-CLOSED_W){1'b0}},
                                         i_cfg.closed_limit_mrad});
    assign diff       = pos_x - {r_prev_pos[POS_W-1], r_prev_pos};
    assign diff_abs   = diff[POS_W] ? (POS_W+1)'(-diff) : diff;
    assign still      = r_prev_valid &&
                        (diff_abs < {{(POS_W+1-TOL_W){1'b0}}, i_cfg.move_tolerance_mrad});
    assign elapsed    = r_in.time_ms - r_stall_start;
    assign fire       = (elapsed > {{(TIME_W-STALL_W){1'b0}}, i_cfg.stall_time_ms})
                        && !r_prot_fired;
    assign backed     = pos_x - $signed({{(POS_W+1-BACKOFF_W){1'b0}}, i_cfg.back_off_mrad});

    always_comb begin
        n_grab_active = r_grab_active;
        n_prev_pos    = r_prev_pos;
        n_prev_valid  = r_prev_valid;
        n_stall_start = r_stall_start;
        n_prot_fired  = r_prot_fired;
        res_valid     = 1'b0;
        res           = '0;
        case (r_in.action) inside
            ACT_GRAB, ACT_RELEASE: begin
                n_grab_active   = (r_in.action == ACT_GRAB);
                n_prot_fired    = 1'b0;
                n_prev_valid    = 1'b0;
                res_valid       = 1'b1;
                res.target_mrad = (r_in.action == ACT_GRAB) ? '0
                                                            : i_cfg.release_angle_mrad;
            end
            ACT_SAMPLE: begin
                if (r_grab_active) begin
                    if (not_closed && still) begin
                        if (fire) begin
                            res_valid       = 1'b1;
                            res.speed_level = 1'b1;
                            res.cause       = 1'b1;
                            res.target_mrad = backed[POS_W] ? '0 : backed[TARGET_W-1:0];
                            n_prot_fired    = 1'b1;
                        end
                    end else begin
                        n_stall_start = r_in.time_ms;
                        n_prot_fired  = 1'b0;
                    end
                    n_prev_pos   = r_in.position_mrad;
                    n_prev_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_load) begin
            r_in_valid <= 1'b1;
        end else if (i_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_in <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grab_active <= 1'b0;
            r_prev_pos    <= '0;
            r_prev_valid  <= 1'b0;
            r_stall_start <= '0;
            r_prot_fired  <= 1'b0;
        end else if (r_in_valid && i_advance) begin
            r_grab_active <= n_grab_active;
            r_prev_pos    <= n_prev_pos;
            r_prev_valid  <= n_prev_valid;
            r_stall_start <= n_stall_start;
            r_prot_fired  <= n_prot_fired;
        end
    end

    assign o_busy      = r_in_valid;
    assign o_res_valid = r_in_valid && res_valid;
    assign o_res       = res;

endmodule

### hw/rtl/gripper_stall_protection.sv
// ---------------------------------------------------------------------------
// gripper_stall_protection: gripper stall watchdog
// Issues fast grab/release moves and one slow back-off move when the gripper
// stalls short of closed for longer than the configured time.
// ---------------------------------------------------------------------------
// Path: the accepted input word is held in the input register, and its command
//   word in the output register.
// Throughput: one word per cycle, set by the single decision stage; a
//   stalled output holds the stage and drops i_item.ready.
// Reset: i_rst_n synchronous, active low; clears the stall state, both
//   valid flags and loads the register defaults.
module gripper_stall_protection
    import gsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    gsp_in_if.sink               i_item,
    gsp_out_if.source            o_result
);

    t_cfg      cfg;
    t_in_word  in_word;
    t_out_word core_res;
    logic      core_busy;
    logic      core_res_valid;
    logic      advance;
    logic      load;

    logic      r_out_valid;
    t_out_word r_out;

    // register file
    gsp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_index (i_cfg_index),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    // decision stage moves whenever the output register is free or draining
    assign advance = !r_out_valid || o_result.ready;
    assign i_item.ready = !core_busy || advance;
    assign load = i_item.valid && i_item.ready;

    assign in_word.action        = i_item.action;
    assign in_word.position_mrad = i_item.position_mrad;
    assign in_word.time_ms       = i_item.time_ms;

    gsp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_load      (load),
        .i_word      (in_word),
        .i_advance   (advance),
        .o_busy      (core_busy),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    // output word register; words that give no command leave it empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= core_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_res_valid) begin
            r_out <= core_res;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.target_mrad = r_out.target_mrad;
    assign o_result.speed_level = r_out.speed_level;
    assign o_result.cause       = r_out.cause;

endmodule

### dv/gripper_stall_protection_tb.sv
// ---------------------------------------------------------------------------
// gripper_stall_protection_tb: self-checking bench for the stall watchdog
// Drives command and position sample words with random gaps, predicts every
// servo command word in step with the DUT and checks each one as it leaves.
// ---------------------------------------------------------------------------
module gripper_stall_protection_tb;
    import gsp_pkg::*;

    localparam int LONG_HOLD_CYCLES = 60;    // receiver hold-off for the pressure test
    localparam int SETTLE_CYCLES    = 6;     // pipeline is 2 deep; a little margin
    localparam int DRAIN_LIMIT      = 4000;  // cycles to wait for outstanding words

    // -----------------------------------------------------------------------
    // Clock, reset, configuration port and the two channels
    // -----------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;

    gsp_in_if  item_ch ();
    gsp_out_if result_ch ();

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    gripper_stall_protection u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    // -----------------------------------------------------------------------
    // Shadow of the block: register copies and stall-watch state.
    // Registers start from the package reset values; reset happens once.
    // -----------------------------------------------------------------------
    logic [STALL_W-1:0]      m_stall    = STALL_TIME_RST;
    logic [BACKOFF_W-1:0]    m_back_off = BACK_OFF_RST;
    logic [TOL_W-1:0]        m_tol      = MOVE_TOL_RST;
    logic [CLOSED_W-1:0]     m_closed   = CLOSED_LIM_RST;
    logic [RELEASE_W-1:0]    m_release  = RELEASE_RST;

    bit                      grab_on    = 1'b0;
    logic signed [POS_W-1:0] last_pos   = '0;
    bit                      last_ok    = 1'b0;
    logic [TIME_W-1:0]       stall_t0   = '0;
    bit                      fired      = 1'b0;

    t_out_word servo_cmd_q[$];   // servo command words still to come out

    int  n_fail        = 0;
    int  n_counted     = 0;      // words that the block acts on
    bit  src_idle_on   = 1'b0;
    bit  snk_idle_on   = 1'b0;
    bit  long_hold_req = 1'b0;

    // Works out what one accepted input word does to the stall watch and
    // queues the servo command it causes, if any. Returns 0 for words that
    // the block simply ignores.
    function automatic bit predict_servo_cmd(input t_action act,
                                             input logic signed [POS_W-1:0] pos,
                                             input logic [TIME_W-1:0] ts);
        t_out_word         w;
        int                pos_i;
        int                diff;
        bit                not_closed;
        bit                still;
        logic [TIME_W-1:0] elapsed;
        w     = '0;
        pos_i = int'(pos);
        // grab or release: new request, forget the previous sample
        if (act == ACT_GRAB || act == ACT_RELEASE) begin
            grab_on       = (act == ACT_GRAB);
            fired         = 1'b0;
            last_ok       = 1'b0;
            w.target_mrad = grab_on ? '0 : m_release;
            servo_cmd_q   = {servo_cmd_q, w};
            return 1'b1;
        end
        // unused action code, or a sample with no grab pending
        if (act != ACT_SAMPLE || !grab_on)
            return 1'b0;
        not_closed = pos_i > int'(m_closed);
        still      = 1'b0;
        if (last_ok) begin
            diff = pos_i - int'(last_pos);
            if (diff < 0)
                diff = -diff;
            still = diff < int'(m_tol);
        end
        if (not_closed && still) begin
            elapsed = ts - stall_t0;     // wraps modulo 2^32
            if (elapsed > {16'd0, m_stall} && !fired) begin
                diff = pos_i - int'(m_back_off);
                if (diff < 0)
                    diff = 0;
                w.target_mrad = diff[TARGET_W-1:0];
                w.speed_level = 1'b1;
                w.cause       = 1'b1;
                servo_cmd_q   = {servo_cmd_q, w};
                fired = 1'b1;
            end
        end else begin
            // moving, closed or first sample: restart the timer
            stall_t0 = ts;
            fired    = 1'b0;
        end
        last_pos = pos;
        last_ok  = 1'b1;
        return 1'b1;
    endfunction

    function automatic logic signed [POS_W-1:0] rand_pos();
        logic signed [POS_W-1:0] v;
        v = POS_W'($urandom());
        return v;
    endfunction

    // -----------------------------------------------------------------------
    // Sender: one word per call, optional idle burst in front of it.
    // Valid stays high after acceptance; an idle burst in a later call or a drain lowers it.
    // -----------------------------------------------------------------------
    task automatic send_word(input t_action act,
                             input logic signed [POS_W-1:0] pos,
                             input logic [TIME_W-1:0] ts);
        int gap;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.action        <= act;
        item_ch.position_mrad <= pos;
        item_ch.time_ms       <= ts;
        @(posedge i_clk);
        while (!item_ch.ready)
            @(posedge i_clk);
        if (predict_servo_cmd(act, pos, ts))
            n_counted++;
    endtask

    // Stop sending and wait for every outstanding command word, then let
    // any word with no result clear the pipeline.
    task automatic wait_drain();
        int guard;
        guard = 0;
        item_ch.valid <= 1'b0;
        while (servo_cmd_q.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (servo_cmd_q.size() != 0) begin
            $display("%0t: %0d command word(s) never arrived", $time, servo_cmd_q.size());
            n_fail++;
            servo_cmd_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_STALL_TIME: m_stall    = val[STALL_W-1:0];
            REG_BACK_OFF:   m_back_off = val[BACKOFF_W-1:0];
            REG_MOVE_TOL:   m_tol      = val[TOL_W-1:0];
            REG_CLOSED_LIM: m_closed   = val[CLOSED_W-1:0];
            REG_RELEASE:    m_release  = val[RELEASE_W-1:0];
            default: ;
        endcase
    endtask

    // Registers only change with the block idle.
    task automatic write_all(input logic [CFG_DAT_W-1:0] stall,
                             input logic [CFG_DAT_W-1:0] back_off,
                             input logic [CFG_DAT_W-1:0] tol,
                             input logic [CFG_DAT_W-1:0] closed,
                             input logic [CFG_DAT_W-1:0] rel);
        wait_drain();
        write_reg(REG_STALL_TIME, stall);
        write_reg(REG_BACK_OFF, back_off);
        write_reg(REG_MOVE_TOL, tol);
        write_reg(REG_CLOSED_LIM, closed);
        write_reg(REG_RELEASE, rel);
    endtask

    // -----------------------------------------------------------------------
    // One grab episode: a grab, then a run of samples that mostly jitter
    // inside the tolerance with time creeping forward, so the stall timer
    // builds up and fires. Mixed in: big moves, closed positions, time
    // jumps, stray action codes, releases and re-grabs.
    // -----------------------------------------------------------------------
    task automatic run_episode();
        int                p;
        int                jit;
        int                step;
        int                r;
        int                len;
        bit                is_sample;
        logic [TIME_W-1:0] ts;
        ts = $urandom();
        if ($urandom_range(0, 7) == 0)
            ts = 32'hFFFF_FFFF - $urandom_range(0, 2 * int'(m_stall) + 64);  // near the wrap
        send_word(ACT_GRAB, rand_pos(), ts);
        p   = $urandom_range(int'(m_closed) + 1, 8191);
        len = $urandom_range(3, 14);
        repeat (len) begin
            r         = $urandom_range(0, 99);
            step      = $urandom_range(0, int'(m_stall) / 2 + 2);
            ts        = ts + step;
            is_sample = 1'b1;
            if (r < 55) begin
                jit = $urandom_range(0, 2 * int'(m_tol));
                p   = p + jit - int'(m_tol);
                if (p > 8191)
                    p = 8191;
                if (p < -8192)
                    p = -8192;
            end else if (r < 68) begin
                jit = $urandom_range(0, 16383);
                p   = jit - 8192;
            end else if (r < 78) begin
                jit = $urandom_range(0, int'(m_closed) + 8192);
                p   = jit - 8192;       // at or below the closed limit
            end else if (r < 84) begin
                send_word(ACT_NONE, rand_pos(), $urandom());
                is_sample = 1'b0;
            end else if (r < 88) begin
                send_word(ACT_RELEASE, rand_pos(), ts);
                is_sample = 1'b0;
            end else if (r < 92) begin
                send_word(ACT_GRAB, rand_pos(), ts);
                is_sample = 1'b0;
            end else if (r < 96) begin
                ts = $urandom();
            end else begin
                step = $urandom_range(int'(m_stall), int'(m_stall) + 3);
                ts   = ts + step;       // right around the threshold
            end
            if (is_sample)
                send_word(ACT_SAMPLE, POS_W'(p), ts);
        end
    endtask

    task automatic run_episodes(input int more);
        int goal;
        goal = n_counted + more;
        while (n_counted < goal)
            run_episode();
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Hand-picked words on the reset settings: thresholds hit exactly and by
    // one, floor at zero, timestamp wrap, closed and negative positions,
    // ignored words and a repeat stall after protection has fired.
    task automatic test_directed_cases();
        send_word(ACT_NONE,    -14'sd1,     32'hFFFF_FFFF);  // unused code
        send_word(ACT_SAMPLE,  14'sd100,    32'd10);         // not grabbing
        send_word(ACT_RELEASE, 14'sd0,      32'd20);
        send_word(ACT_GRAB,    14'sd0,      32'd0);
        send_word(ACT_SAMPLE,  14'sd8191,   32'd1000);       // first sample
        send_word(ACT_SAMPLE,  14'sd8191,   32'd1400);
        send_word(ACT_SAMPLE,  14'sd8190,   32'd1501);       // just over: fires
        send_word(ACT_SAMPLE,  14'sd8191,   32'd5000);       // already fired
        send_word(ACT_SAMPLE,  14'sd8100,   32'd5001);       // moved: restart
        send_word(ACT_SAMPLE,  14'sd8102,   32'd5501);       // exactly the limit
        send_word(ACT_SAMPLE,  14'sd8104,   32'd5502);       // fires
        send_word(ACT_SAMPLE,  14'sd51,     32'd7000);
        send_word(ACT_SAMPLE,  14'sd51,     32'd8000);       // back-off floored
        send_word(ACT_SAMPLE,  14'sd50,     32'd9000);       // at the closed limit
        send_word(ACT_SAMPLE,  14'sd50,     32'd9600);
        send_word(ACT_SAMPLE,  -14'sd8192,  32'd10000);      // negative counts as closed
        send_word(ACT_NONE,    14'sd8191,   32'd0);
        send_word(ACT_GRAB,    -14'sd8192,  32'hFFFF_FF00);
        send_word(ACT_SAMPLE,  14'sd3000,   32'hFFFF_FF00);
        send_word(ACT_SAMPLE,  14'sd3004,   32'h0000_0010);  // across the wrap
        send_word(ACT_SAMPLE,  14'sd3000,   32'h0000_0110);  // fires after wrap
        send_word(ACT_SAMPLE,  14'sd3005,   32'h0000_0111);  // change equals tolerance
        send_word(ACT_RELEASE, 14'sd0,      32'h0000_0200);
        send_word(ACT_SAMPLE,  14'sd3005,   32'h0000_0300);  // ignored after release
        wait_drain();
    endtask

    // Every register at its floor, then at its ceiling.
    task automatic test_register_extremes();
        write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_episodes(80);
        write_all(16'hFFFF, 16'd4095, 16'd255, 16'd1023, 16'd8191);
        run_episodes(80);
    endtask

    // Receiver holds off for a long stretch while commands keep coming, so
    // the block fills and drops ready; then the sender waits for it all.
    task automatic test_output_backpressure();
        write_all(16'd300, 16'd100, 16'd10, 16'd40, 16'd4000);
        long_hold_req = 1'b1;
        repeat (12) begin
            send_word(ACT_GRAB, rand_pos(), $urandom());
            send_word(ACT_RELEASE, rand_pos(), $urandom());
        end
        wait_drain();
    endtask

    // Random settings, short stall times mostly so protection fires often.
    task automatic test_random_settings();
        int stall;
        repeat (4) begin
            stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 400);
            write_all(CFG_DAT_W'(stall), CFG_DAT_W'($urandom_range(0, 4095)),
                      CFG_DAT_W'($urandom_range(0, 255)),
                      CFG_DAT_W'($urandom_range(0, 1023)),
                      CFG_DAT_W'($urandom_range(0, 8191)));
            run_episodes(110);
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_full_rate();
        wait_drain();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        write_all(16'd150, 16'd200, 16'd5, 16'd50, 16'd1600);
        run_episodes(100);
    endtask

    // -----------------------------------------------------------------------
    // Receiver: random ready bursts, plus the long hold-off on request
    // -----------------------------------------------------------------------
    initial begin : result_sink
        int n;
        int k;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                for (k = 1; k < LONG_HOLD_CYCLES; k++)
                    @(posedge i_clk);
            end else if (snk_idle_on && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 4);
                result_ch.ready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Checker: each accepted command word against the oldest prediction
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (servo_cmd_q.size() == 0) begin
                n_fail++;
                $display("%0t: command word expected none actual target %0d speed %0d cause %0d",
                         $time, result_ch.target_mrad, result_ch.speed_level,
                         result_ch.cause);
            end else begin
                want = servo_cmd_q.pop_front();
                if (result_ch.target_mrad !== want.target_mrad) begin
                    n_fail++;
                    $display("%0t: target_mrad expected %0d actual %0d",
                             $time, want.target_mrad, result_ch.target_mrad);
                end
                if (result_ch.speed_level !== want.speed_level) begin
                    n_fail++;
                    $display("%0t: speed_level expected %0d actual %0d",
                             $time, want.speed_level, result_ch.speed_level);
                end
                if (result_ch.cause !== want.cause) begin
                    n_fail++;
                    $display("%0t: cause expected %0d actual %0d",
                             $time, want.cause, result_ch.cause);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sequence of tests
    // -----------------------------------------------------------------------
    initial begin : run_tests
        i_rst_n               = 1'b0;
        i_cfg_wr_en           = 1'b0;
        i_cfg_index           = '0;
        i_cfg_wdata           = '0;
        item_ch.valid         = 1'b0;
        item_ch.action        = ACT_NONE;
        item_ch.position_mrad = '0;
        item_ch.time_ms       = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words on the reset settings, idling on both sides
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        test_directed_cases();
        test_register_extremes();
        test_output_backpressure();
        test_random_settings();
        test_full_rate();

        wait_drain();
        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #(12 * 400000);
        $display("%0t: run timed out", $time);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
hw/rtl/gsp_pkg.sv
hw/rtl/gsp_in_if.sv
hw/rtl/gsp_out_if.sv
hw/rtl/gsp_cfg_regs.sv
hw/rtl/gsp_core.sv
hw/rtl/gripper_stall_protection.sv
dv/gripper_stall_protection_tb.sv
